// File: hdl/srtf_pkg.sv
package srtf_pkg;

  // Sizing of the process table and of the time fields.
  localparam int MAX_PROCESSES = 16;
  localparam int TIME_BITS     = 12;
  localparam int IDX_W         = $clog2(MAX_PROCESSES);
  localparam int CNT_W         = $clog2(MAX_PROCESSES + 1);
  localparam int CT_W          = 17;
  localparam int TOT_W         = 22;
  localparam int PROC_W        = 2 * TIME_BITS;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_OUT_RD,
    ST_OUT_SUB,
    ST_OUT_SUM,
    ST_OUT_WAIT
  } state_e;

  // Outcome of one pass over the process table.
  typedef struct packed {
    logic                 found;
    logic [IDX_W-1:0]     pick;
    logic [TIME_BITS-1:0] best;
    logic                 have_next;
    logic [TIME_BITS-1:0] next_arr;
  } scan_res_t;

endpackage

// File: hdl/srtf_ram.sv
module srtf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/srtf_scan.sv
module srtf_scan (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           clear_i,
  input  logic                           en_i,
  input  logic [srtf_pkg::IDX_W-1:0]     idx_i,
  input  logic [srtf_pkg::TIME_BITS-1:0] rem_i,
  input  logic [srtf_pkg::TIME_BITS-1:0] arr_i,
  input  logic [srtf_pkg::CT_W-1:0]      time_i,
  output srtf_pkg::scan_res_t            res_o
);
  import srtf_pkg::*;

  scan_res_t res_q, res_d;
  logic      live;
  logic      arrived;

  assign live    = (rem_i != '0);
  assign arrived = (CT_W'(arr_i) <= time_i);

  // Fold one table entry into the running best pick and next arrival.
  always_comb begin
    res_d = res_q;
    if (clear_i) begin
      res_d.found     = 1'b0;
      res_d.have_next = 1'b0;
    end else if (en_i && live) begin
      if (arrived) begin
        if (!res_q.found || (rem_i < res_q.best)) begin
          res_d.found = 1'b1;
          res_d.best  = rem_i;
          res_d.pick  = idx_i;
        end
      end else if (!res_q.have_next || (arr_i < res_q.next_arr)) begin
        res_d.have_next = 1'b1;
        res_d.next_arr  = arr_i;
      end
    end
  end

  // Running result of the current pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// File: hdl/srtf_schedule_simulator_core.sv
// Shortest-remaining-time-first schedule simulator.
// Input channel (in_valid_i / in_ready_o): one process per transfer, with its
// arrival time and burst time; a burst of zero counts as one. Processes take
// indexes from 0 in load order, up to 16; further ones are dropped. Loading
// runs at one transfer per cycle. The transfer with last_process_i set ends
// the set and starts the simulation; in_ready_o stays low until the run ends.
// Each scheduling step makes one pass over the loaded table through a single
// compare unit: one read per process, then a drain of the read and compare
// registers, one decide state and one update state; an idle gap skips straight
// to the next arrival. A run of n processes has at most about 2n steps, since
// each step ends at an arrival or a completion.
// Results then leave on the output channel (out_valid_o / out_ready_i) in
// index order, one at a time once the one before is taken; the last one
// carries last_result_o and the totals. A stalled receiver holds the result
// register and freezes the block. Reset empties the set and returns the
// block to loading; the table contents are not cleared.
module srtf_schedule_simulator_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [srtf_pkg::TIME_BITS-1:0] arrival_time_i,
  input  logic [srtf_pkg::TIME_BITS-1:0] burst_time_i,
  input  logic                           last_process_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [srtf_pkg::IDX_W-1:0]     process_index_o,
  output logic [srtf_pkg::CT_W-1:0]      completion_time_o,
  output logic [srtf_pkg::CT_W-1:0]      turnaround_time_o,
  output logic [srtf_pkg::CT_W-1:0]      waiting_time_o,
  output logic [srtf_pkg::TOT_W-1:0]     total_turnaround_o,
  output logic [srtf_pkg::TOT_W-1:0]     total_waiting_o,
  output logic                           last_result_o
);
  import srtf_pkg::*;

  state_e state_q, state_d;

  logic [CNT_W-1:0]     loaded_q, loaded_d;
  logic [CNT_W-1:0]     n_q, n_d;
  logic [CNT_W-1:0]     fin_q, fin_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 pend_q, pend_d;
  logic [IDX_W-1:0]     didx_q, didx_d;
  logic [CT_W-1:0]      time_q, time_d;
  logic [TIME_BITS-1:0] run_q, run_d;
  logic [IDX_W-1:0]     out_idx_q, out_idx_d;
  logic [CT_W-1:0]      tat_q, tat_d;
  logic [TOT_W-1:0]     tot_tat_q, tot_tat_d;
  logic [TOT_W-1:0]     tot_wt_q, tot_wt_d;
  logic                 out_valid_q, out_valid_d;
  logic [CT_W-1:0]      cmp_out_q, cmp_out_d;
  logic [CT_W-1:0]      tat_out_q, tat_out_d;
  logic [CT_W-1:0]      wt_out_q, wt_out_d;
  logic [TOT_W-1:0]     tot_tat_out_q, tot_tat_out_d;
  logic [TOT_W-1:0]     tot_wt_out_q, tot_wt_out_d;
  logic                 last_out_q, last_out_d;

  // Table memories and their ports.
  logic                 proc_we, rem_we, cmp_we;
  logic [IDX_W-1:0]     rem_waddr, raddr;
  logic [PROC_W-1:0]    proc_wdata, proc_rdata;
  logic [TIME_BITS-1:0] rem_wdata, rem_rdata;
  logic [CT_W-1:0]      cmp_rdata;
  logic [TIME_BITS-1:0] arr_rd, bur_rd;
  logic [TIME_BITS-1:0] bur_in;

  // Scan unit control and result.
  logic      scan_clear, scan_en;
  scan_res_t scan;

  // Datapath terms.
  logic [CT_W-1:0]      gap;
  logic [TIME_BITS-1:0] new_rem;
  logic [CT_W-1:0]      time_next;
  logic [CT_W-1:0]      wt_now;
  logic                 in_xfer, out_xfer, is_last_idx;

  assign arr_rd      = proc_rdata[PROC_W-1:TIME_BITS];
  assign bur_rd      = proc_rdata[TIME_BITS-1:0];
  assign bur_in      = (burst_time_i == '0) ? TIME_BITS'(1) : burst_time_i;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_xfer    = out_valid_q && out_ready_i;
  assign gap         = CT_W'(scan.next_arr) - time_q;
  assign new_rem     = scan.best - run_q;
  assign time_next   = time_q + CT_W'(run_q);
  assign wt_now      = tat_q - CT_W'(bur_rd);
  assign is_last_idx = ((CNT_W'(out_idx_q) + CNT_W'(1)) == n_q);

  assign proc_wdata = {arrival_time_i, bur_in};
  assign rem_wdata  = (state_q == ST_LOAD) ? bur_in : new_rem;
  assign rem_waddr  = (state_q == ST_LOAD) ? loaded_q[IDX_W-1:0] : scan.pick;
  assign raddr      = (state_q == ST_SCAN) ? cnt_q[IDX_W-1:0] : out_idx_q;

  // Sequencer: load, scan and step the schedule, then stream results.
  always_comb begin
    state_d       = state_q;
    loaded_d      = loaded_q;
    n_d           = n_q;
    fin_d         = fin_q;
    cnt_d         = cnt_q;
    pend_d        = 1'b0;
    didx_d        = cnt_q[IDX_W-1:0];
    time_d        = time_q;
    run_d         = run_q;
    out_idx_d     = out_idx_q;
    tat_d         = tat_q;
    tot_tat_d     = tot_tat_q;
    tot_wt_d      = tot_wt_q;
    out_valid_d   = out_valid_q;
    cmp_out_d     = cmp_out_q;
    tat_out_d     = tat_out_q;
    wt_out_d      = wt_out_q;
    tot_tat_out_d = tot_tat_out_q;
    tot_wt_out_d  = tot_wt_out_q;
    last_out_d    = last_out_q;
    proc_we       = 1'b0;
    rem_we        = 1'b0;
    cmp_we        = 1'b0;
    scan_clear    = 1'b0;
    scan_en       = 1'b0;
    in_ready_o    = 1'b0;

    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_xfer) begin
          if (loaded_q < CNT_W'(MAX_PROCESSES)) begin
            proc_we  = 1'b1;
            rem_we   = 1'b1;
            loaded_d = loaded_q + CNT_W'(1);
          end
          if (last_process_i) begin
            n_d        = loaded_d;
            fin_d      = '0;
            time_d     = '0;
            cnt_d      = '0;
            scan_clear = 1'b1;
            state_d    = ST_SCAN;
          end
        end
      end

      // Issue one read per cycle; the scan unit sees the data in the cycle after.
      ST_SCAN: begin
        scan_en = pend_q;
        if (cnt_q < n_q) begin
          pend_d = 1'b1;
          cnt_d  = cnt_q + CNT_W'(1);
        end else if (!pend_q) begin
          state_d = ST_DECIDE;
        end
      end

      // Either jump over an idle gap or size the next run.
      ST_DECIDE: begin
        if (!scan.found) begin
          time_d     = CT_W'(scan.next_arr);
          cnt_d      = '0;
          scan_clear = 1'b1;
          state_d    = ST_SCAN;
        end else begin
          if (scan.have_next && (gap < CT_W'(scan.best))) begin
            run_d = gap[TIME_BITS-1:0];
          end else begin
            run_d = scan.best;
          end
          state_d = ST_UPDATE;
        end
      end

      ST_UPDATE: begin
        rem_we     = 1'b1;
        time_d     = time_next;
        cnt_d      = '0;
        scan_clear = 1'b1;
        state_d    = ST_SCAN;
        if (new_rem == '0) begin
          cmp_we = 1'b1;
          fin_d  = fin_q + CNT_W'(1);
          if (fin_d == n_q) begin
            out_idx_d = '0;
            tot_tat_d = '0;
            tot_wt_d  = '0;
            state_d   = ST_OUT_RD;
          end
        end
      end

      ST_OUT_RD: begin
        state_d = ST_OUT_SUB;
      end

      ST_OUT_SUB: begin
        tat_d   = cmp_rdata - CT_W'(arr_rd);
        state_d = ST_OUT_SUM;
      end

      // Build the result and fold it into the totals.
      ST_OUT_SUM: begin
        tot_tat_d   = tot_tat_q + TOT_W'(tat_q);
        tot_wt_d    = tot_wt_q + TOT_W'(wt_now);
        cmp_out_d   = cmp_rdata;
        tat_out_d   = tat_q;
        wt_out_d    = wt_now;
        last_out_d  = is_last_idx;
        out_valid_d = 1'b1;
        if (is_last_idx) begin
          tot_tat_out_d = tot_tat_d;
          tot_wt_out_d  = tot_wt_d;
        end else begin
          tot_tat_out_d = '0;
          tot_wt_out_d  = '0;
        end
        state_d = ST_OUT_WAIT;
      end

      ST_OUT_WAIT: begin
        if (out_xfer) begin
          out_valid_d = 1'b0;
          if (last_out_q) begin
            loaded_d = '0;
            fin_d    = '0;
            time_d   = '0;
            state_d  = ST_LOAD;
          end else begin
            out_idx_d = out_idx_q + IDX_W'(1);
            state_d   = ST_OUT_RD;
          end
        end
      end

      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      loaded_q    <= '0;
      n_q         <= '0;
      fin_q       <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      time_q      <= '0;
      out_idx_q   <= '0;
      out_valid_q <= 1'b0;
      last_out_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      loaded_q    <= loaded_d;
      n_q         <= n_d;
      fin_q       <= fin_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      time_q      <= time_d;
      out_idx_q   <= out_idx_d;
      out_valid_q <= out_valid_d;
      last_out_q  <= last_out_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    didx_q        <= didx_d;
    run_q         <= run_d;
    tat_q         <= tat_d;
    tot_tat_q     <= tot_tat_d;
    tot_wt_q      <= tot_wt_d;
    cmp_out_q     <= cmp_out_d;
    tat_out_q     <= tat_out_d;
    wt_out_q      <= wt_out_d;
    tot_tat_out_q <= tot_tat_out_d;
    tot_wt_out_q  <= tot_wt_out_d;
  end

  srtf_ram #(
    .WIDTH (PROC_W),
    .DEPTH (MAX_PROCESSES)
  ) u_proc_ram (
    .clk_i   (clk_i),
    .we_i    (proc_we),
    .waddr_i (loaded_q[IDX_W-1:0]),
    .wdata_i (proc_wdata),
    .raddr_i (raddr),
    .rdata_o (proc_rdata)
  );

  srtf_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (MAX_PROCESSES)
  ) u_rem_ram (
    .clk_i   (clk_i),
    .we_i    (rem_we),
    .waddr_i (rem_waddr),
    .wdata_i (rem_wdata),
    .raddr_i (raddr),
    .rdata_o (rem_rdata)
  );

  srtf_ram #(
    .WIDTH (CT_W),
    .DEPTH (MAX_PROCESSES)
  ) u_cmp_ram (
    .clk_i   (clk_i),
    .we_i    (cmp_we),
    .waddr_i (scan.pick),
    .wdata_i (time_next),
    .raddr_i (raddr),
    .rdata_o (cmp_rdata)
  );

  srtf_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (scan_clear),
    .en_i    (scan_en),
    .idx_i   (didx_q),
    .rem_i   (rem_rdata),
    .arr_i   (arr_rd),
    .time_i  (time_q),
    .res_o   (scan)
  );

  assign out_valid_o        = out_valid_q;
  assign process_index_o    = out_idx_q;
  assign completion_time_o  = cmp_out_q;
  assign turnaround_time_o  = tat_out_q;
  assign waiting_time_o     = wt_out_q;
  assign total_turnaround_o = tot_tat_out_q;
  assign total_waiting_o    = tot_wt_out_q;
  assign last_result_o      = last_out_q;

  // A result is never offered while the block takes new processes.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("result offered while loading");

  // The finished count never passes the size of the set.
  a_fin_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q <= n_q)
    else $error("more processes finished than loaded");

  // The final result belongs to the highest loaded index.
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_result_o) |-> (CNT_W'(process_index_o) + CNT_W'(1) == n_q))
    else $error("final result at wrong index");

  // Taking the final result returns the block to loading.
  a_back_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_result_o) |=> (in_ready_o && !out_valid_o))
    else $error("block did not return to loading after the run");

endmodule
